// File: design/alds_pkg.sv
`timescale 1ns / 1ps

package alds_pkg;

   localparam int MAX_LEDS      = 32;
   localparam int LED_IDX_W     = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int LED_POS_W     = $clog2(MAX_LEDS + 1);
   localparam int BITS_PER_LED  = 24;
   localparam int BIT_POS_W     = $clog2(BITS_PER_LED + 1);
   localparam int WORD_W        = 24;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 10;

   typedef enum logic [1:0] {
      CMD_SET_PIXEL = 2'd0,
      CMD_SET_ALL   = 2'd1,
      CMD_START     = 2'd2,
      CMD_TICK      = 2'd3
   } cmd_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_LED_COUNT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_PERIOD   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_BITS   = 3'd4;

   typedef struct packed {
      cmd_type    cmd;
      logic [4:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic data_level;
      logic busy_res;
      logic accepted;
   } rsp_type;

   typedef struct packed {
      logic [5:0] led_count;
      logic [7:0] bit_period;
      logic [7:0] zero_high_ticks;
      logic [7:0] one_high_ticks;
      logic [9:0] reset_bit_count;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      led_count:       6'd25,
      bit_period:      8'd77,
      zero_high_ticks: 8'd22,
      one_high_ticks:  8'd50,
      reset_bit_count: 10'd240
   };

   // Commands from the sequencer to the serializer.
   typedef struct packed {
      logic              start;
      logic              tick;
      logic              load;
      logic [WORD_W-1:0] load_word;
   } ser_ctl_type;

   typedef struct packed {
      logic                 busy;
      logic                 busy_next;
      logic                 level_next;
      logic                 load_req;
      logic [LED_IDX_W-1:0] load_addr;
   } ser_status_type;

   function automatic logic [LED_POS_W-1:0] active_leds(input logic [5:0] count);
      if (int'(count) > MAX_LEDS) begin
         return LED_POS_W'(MAX_LEDS);
      end
      return LED_POS_W'(count);
   endfunction

endpackage

// File: design/alds_pixel_ram.sv
`timescale 1ns / 1ps

module alds_pixel_ram (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [alds_pkg::LED_IDX_W-1:0]      wr_addr,
   input  logic [alds_pkg::WORD_W-1:0]         wr_data,
   input  logic                                rd_en,
   input  logic [alds_pkg::LED_IDX_W-1:0]      rd_addr,
   output logic [alds_pkg::WORD_W-1:0]         rd_data
);

   logic [alds_pkg::WORD_W-1:0]   mem [alds_pkg::MAX_LEDS];
   logic [alds_pkg::MAX_LEDS-1:0] valid_ff;
   logic [alds_pkg::WORD_W-1:0]   rd_word_ff;
   logic                          rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Entries never written since reset read as black.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= (wr_en && (wr_addr == rd_addr)) || valid_ff[rd_addr];
         end
      end
   end

   // A read of the entry being written in the same cycle returns the new word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_word_ff <= wr_data;
         end else begin
            rd_word_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

// File: design/alds_serializer.sv
`timescale 1ns / 1ps

module alds_serializer (
   input  logic                     clock,
   input  logic                     reset,
   input  alds_pkg::cfg_type        cfg,
   input  alds_pkg::ser_ctl_type    ctl,
   output alds_pkg::ser_status_type status
);

   logic                           busy_ff, busy_in;
   logic                           in_gap_ff, in_gap_in;
   logic [alds_pkg::LED_POS_W-1:0] led_ff, led_in;
   logic [alds_pkg::BIT_POS_W-1:0] bit_ff, bit_in;
   logic [7:0]                     tick_ff, tick_in;
   logic [9:0]                     gap_ff, gap_in;
   logic [alds_pkg::WORD_W-1:0]    shift_ff, shift_in;

   logic [alds_pkg::LED_POS_W-1:0] active;
   logic [alds_pkg::LED_POS_W-1:0] led_inc;
   logic [alds_pkg::BIT_POS_W-1:0] bit_inc;
   logic [9:0]                     gap_inc;
   logic [7:0]                     high_ticks;
   logic                           finish;

   always_comb begin
      busy_in   = busy_ff;
      in_gap_in = in_gap_ff;
      led_in    = led_ff;
      bit_in    = bit_ff;
      tick_in   = tick_ff;
      gap_in    = gap_ff;
      shift_in  = shift_ff;
      finish    = 1'b0;
      status.load_req  = 1'b0;
      status.load_addr = '0;

      active  = alds_pkg::active_leds(cfg.led_count);
      led_inc = led_ff + alds_pkg::LED_POS_W'(1);
      bit_inc = bit_ff + alds_pkg::BIT_POS_W'(1);
      gap_inc = gap_ff + 10'd1;

      if (ctl.start) begin
         busy_in   = 1'b1;
         in_gap_in = 1'b0;
         led_in    = '0;
         bit_in    = '0;
         tick_in   = '0;
         gap_in    = '0;
         if (active == '0) begin
            in_gap_in = 1'b1;
            shift_in  = '0;
            finish    = (cfg.reset_bit_count == '0);
         end else begin
            status.load_req = 1'b1;
         end
      end else if (ctl.tick) begin
         if (tick_ff < cfg.bit_period) begin
            tick_in = tick_ff + 8'd1;
         end else begin
            tick_in = '0;
            if (in_gap_ff) begin
               gap_in = gap_inc;
               finish = (gap_inc >= cfg.reset_bit_count);
            end else begin
               shift_in = {shift_ff[alds_pkg::WORD_W-2:0], 1'b0};
               bit_in   = bit_inc;
               if (bit_inc >= alds_pkg::BIT_POS_W'(alds_pkg::BITS_PER_LED)) begin
                  bit_in = '0;
                  led_in = led_inc;
                  if (led_inc >= active) begin
                     in_gap_in = 1'b1;
                     gap_in    = '0;
                     shift_in  = '0;
                     finish    = (cfg.reset_bit_count == '0);
                  end else begin
                     // The next LED's word arrives from the store in the next cycle.
                     status.load_req  = 1'b1;
                     status.load_addr = led_inc[alds_pkg::LED_IDX_W-1:0];
                  end
               end
            end
         end
      end

      if (finish) begin
         busy_in   = 1'b0;
         in_gap_in = 1'b0;
         led_in    = '0;
         bit_in    = '0;
         tick_in   = '0;
         gap_in    = '0;
         shift_in  = '0;
      end

      if (ctl.load) begin
         shift_in = ctl.load_word;
      end

      high_ticks = shift_in[alds_pkg::WORD_W-1] ? cfg.one_high_ticks : cfg.zero_high_ticks;
      status.level_next = busy_in && !in_gap_in && (tick_in < high_ticks);
      status.busy_next  = busy_in;
      status.busy       = busy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         in_gap_ff <= 1'b0;
         led_ff    <= '0;
         bit_ff    <= '0;
         tick_ff   <= '0;
         gap_ff    <= '0;
         shift_ff  <= '0;
      end else begin
         busy_ff   <= busy_in;
         in_gap_ff <= in_gap_in;
         led_ff    <= led_in;
         bit_ff    <= bit_in;
         tick_ff   <= tick_in;
         gap_ff    <= gap_in;
         shift_ff  <= shift_in;
      end
   end

endmodule

// File: design/addressable_led_strip_driver.sv
`timescale 1ns / 1ps
// Set pixel, ignored commands and ticks within an LED: registered result, valid in the cycle after the transfer.
// Start with LEDs in use, and a tick that opens the next LED: the pixel memory read, then ST_LOAD and the result.
// Set all with LEDs in use: ST_FILL writes each LED in use and reads LED 0 with the last write, then ST_LOAD.
// Throughput is one item per cycle on the short paths while results are taken.
// Reset (synchronous) clears the store to black at once through per-entry valid bits.

module addressable_led_strip_driver (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  alds_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output alds_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [alds_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [alds_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [2:0] {
      ST_READY = 3'b001,
      ST_FILL  = 3'b010,
      ST_LOAD  = 3'b100
   } state_type;

   state_type                      state_ff, state_in;
   alds_pkg::cfg_type              cfg_ff, cfg_in;
   alds_pkg::rsp_type              rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [alds_pkg::LED_IDX_W-1:0] fill_ff, fill_in;
   logic [alds_pkg::WORD_W-1:0]    colour_ff, colour_in;

   alds_pkg::ser_ctl_type          ctl;
   alds_pkg::ser_status_type       status;
   logic [alds_pkg::LED_POS_W-1:0] active;
   logic                           wr_en;
   logic [alds_pkg::LED_IDX_W-1:0] wr_addr;
   logic [alds_pkg::WORD_W-1:0]    wr_data;
   logic                           rd_en;
   logic [alds_pkg::LED_IDX_W-1:0] rd_addr;
   logic [alds_pkg::WORD_W-1:0]    rd_data;
   logic                           rsp_load;
   logic                           acc;
   logic                           req_xfer;

   alds_pixel_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   alds_serializer u_ser (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .ctl    (ctl),
      .status (status)
   );

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign req_ready   = (state_ff == ST_READY) && (!rsp_valid_ff || rsp_ready);
   assign req_xfer    = req_valid && req_ready;
   assign active      = alds_pkg::active_leds(cfg_ff.led_count);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            alds_pkg::CSR_LED_COUNT:  cfg_in.led_count       = csr_wdata[5:0];
            alds_pkg::CSR_BIT_PERIOD: cfg_in.bit_period      = csr_wdata[7:0];
            alds_pkg::CSR_ZERO_HIGH:  cfg_in.zero_high_ticks = csr_wdata[7:0];
            alds_pkg::CSR_ONE_HIGH:   cfg_in.one_high_ticks  = csr_wdata[7:0];
            alds_pkg::CSR_RESET_BITS: cfg_in.reset_bit_count = csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      colour_in    = colour_ff;
      ctl          = '0;
      wr_en        = 1'b0;
      wr_addr      = alds_pkg::LED_IDX_W'(req_payload.pixel_index);
      wr_data      = {req_payload.green, req_payload.red, req_payload.blue};
      rd_en        = 1'b0;
      rd_addr      = status.load_addr;
      rsp_load     = 1'b0;
      acc          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_READY: begin
            if (req_xfer) begin
               unique case (req_payload.cmd)
                  alds_pkg::CMD_SET_PIXEL: begin
                     acc      = int'(req_payload.pixel_index) < int'(active);
                     wr_en    = acc;
                     rsp_load = 1'b1;
                  end
                  alds_pkg::CMD_SET_ALL: begin
                     if (status.busy) begin
                        rsp_load = 1'b1;
                     end else if (active == '0) begin
                        ctl.start = 1'b1;
                        acc       = 1'b1;
                        rsp_load  = 1'b1;
                     end else begin
                        colour_in = {req_payload.green, req_payload.red, req_payload.blue};
                        fill_in   = '0;
                        state_in  = ST_FILL;
                     end
                  end
                  alds_pkg::CMD_START: begin
                     if (status.busy) begin
                        rsp_load = 1'b1;
                     end else begin
                        ctl.start = 1'b1;
                        acc       = 1'b1;
                        if (status.load_req) begin
                           rd_en    = 1'b1;
                           state_in = ST_LOAD;
                        end else begin
                           rsp_load = 1'b1;
                        end
                     end
                  end
                  alds_pkg::CMD_TICK: begin
                     if (!status.busy) begin
                        rsp_load = 1'b1;
                     end else begin
                        ctl.tick = 1'b1;
                        acc      = 1'b1;
                        if (status.load_req) begin
                           rd_en    = 1'b1;
                           state_in = ST_LOAD;
                        end else begin
                           rsp_load = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = fill_ff;
            wr_data = colour_ff;
            fill_in = fill_ff + alds_pkg::LED_IDX_W'(1);
            // The frame starts with the last write; the memory forwards LED 0 if it is that one.
            if (alds_pkg::LED_POS_W'(fill_ff) == (active - alds_pkg::LED_POS_W'(1))) begin
               ctl.start = 1'b1;
               rd_en     = 1'b1;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctl.load      = 1'b1;
            ctl.load_word = rd_data;
            acc           = 1'b1;
            rsp_load      = 1'b1;
            state_in      = ST_READY;
         end
         default: begin
            state_in = ST_READY;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.data_level  = status.level_next;
         rsp_in.busy_res    = status.busy_next;
         rsp_in.accepted    = acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READY;
         cfg_ff       <= alds_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      colour_ff <= colour_in;
   end

   a_load_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> $past(rd_en))
      else $error("pixel load without a preceding memory read");

   a_idle_line_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.busy_res) |-> !rsp_ff.data_level)
      else $error("data line high while not busy");

   a_idle_tick_ignored: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_payload.cmd == alds_pkg::CMD_TICK) && !status.busy)
      |=> (rsp_valid_ff && !rsp_ff.accepted))
      else $error("tick while idle was not answered as ignored");

endmodule

// File: tb/addressable_led_strip_driver_tb.sv
`timescale 1ns / 1ps

module addressable_led_strip_driver_tb;
   import alds_pkg::*;

   localparam int PHASES      = 13;
   localparam int PHASE_ITEMS = 115;
   localparam int LONG_HOLD   = 300;

   logic clock;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_LED_COUNT;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   addressable_led_strip_driver dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Shadow copy of the strip driver: pixel colors, serializer position and registers.
   logic [23:0] pixel_mem [MAX_LEDS];
   bit          busy_q;
   bit          gap_q;
   int          led_pos;
   int          bit_pos;
   logic [7:0]  tick_cnt;
   logic [9:0]  gap_cnt;
   logic [23:0] shift_q;
   cfg_type     cfg_q = CFG_RESET;

   req_type pixel_cmds[$];
   rsp_type strip_rsp_due[$];

   bit req_took = 1'b0;
   bit no_idle = 1'b0;
   int send_gap = 0;
   int rsp_wait = 0;
   int hold_asked = 0;
   int hold_done = 0;
   int err_count = 0;
   int items_sent = 0;
   int taken_items = 0;
   int reg_writes = 0;
   int frames_done = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic int leds_in_use();
      return (cfg_q.led_count > MAX_LEDS) ? MAX_LEDS : int'(cfg_q.led_count);
   endfunction

   function automatic void frame_clear();
      busy_q = 1'b0;
      gap_q = 1'b0;
      gap_cnt = '0;
      tick_cnt = '0;
      bit_pos = 0;
      led_pos = 0;
      shift_q = '0;
   endfunction

   function automatic void gap_open();
      gap_q = 1'b1;
      gap_cnt = '0;
      shift_q = '0;
      if (cfg_q.reset_bit_count == 0) frame_clear();
   endfunction

   function automatic void frame_begin();
      busy_q = 1'b1;
      led_pos = 0;
      bit_pos = 0;
      tick_cnt = '0;
      gap_cnt = '0;
      gap_q = 1'b0;
      if (leds_in_use() == 0) gap_open();
      else shift_q = pixel_mem[0];
   endfunction

   function automatic void tick_once();
      if (tick_cnt < cfg_q.bit_period) begin
         tick_cnt = tick_cnt + 8'd1;
         return;
      end
      tick_cnt = '0;
      if (gap_q) begin
         gap_cnt = gap_cnt + 10'd1;
         if (gap_cnt >= cfg_q.reset_bit_count) frame_clear();
         return;
      end
      shift_q = shift_q << 1;
      bit_pos++;
      if (bit_pos >= BITS_PER_LED) begin
         bit_pos = 0;
         led_pos++;
         if (led_pos >= leds_in_use()) gap_open();
         else shift_q = pixel_mem[led_pos];
      end
   endfunction

   // Applies one command to the shadow state and returns the result the block should give.
   function automatic rsp_type strip_next(req_type r);
      rsp_type     o;
      logic [23:0] colour;
      logic [7:0]  high_ticks;
      bit          took;
      bit          was_busy;
      colour = {r.green, r.red, r.blue};
      took = 1'b0;
      was_busy = busy_q;
      case (r.cmd)
         CMD_SET_PIXEL: begin
            if (r.pixel_index < leds_in_use()) begin
               pixel_mem[r.pixel_index] = colour;
               took = 1'b1;
            end
         end
         CMD_SET_ALL: begin
            if (!busy_q) begin
               for (int i = 0; i < leds_in_use(); i++) pixel_mem[i] = colour;
               frame_begin();
               took = 1'b1;
            end
         end
         CMD_START: begin
            if (!busy_q) begin
               frame_begin();
               took = 1'b1;
            end
         end
         default: begin
            if (busy_q) begin
               tick_once();
               took = 1'b1;
            end
         end
      endcase
      if (was_busy && !busy_q) frames_done++;
      high_ticks = shift_q[23] ? cfg_q.one_high_ticks : cfg_q.zero_high_ticks;
      o.data_level = busy_q && !gap_q && (tick_cnt < high_ticks);
      o.busy_res = busy_q;
      o.accepted = took;
      return o;
   endfunction

   function automatic void reg_store(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_LED_COUNT:  cfg_q.led_count = val[5:0];
         CSR_BIT_PERIOD: cfg_q.bit_period = val[7:0];
         CSR_ZERO_HIGH:  cfg_q.zero_high_ticks = val[7:0];
         CSR_ONE_HIGH:   cfg_q.one_high_ticks = val[7:0];
         CSR_RESET_BITS: cfg_q.reset_bit_count = val;
         default: ;
      endcase
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type led_cmd(cmd_type c, int idx, int red, int green, int blue);
      req_type r;
      r.cmd = c;
      r.pixel_index = 5'(idx);
      r.red = 8'(red);
      r.green = 8'(green);
      r.blue = 8'(blue);
      return r;
   endfunction

   // While a frame runs, ticks dominate so frames reach their latch gap; when idle,
   // writes and starts dominate.
   function automatic req_type random_cmd();
      req_type r;
      int      roll;
      int      n;
      r.pixel_index = 5'($urandom_range(0, 31));
      r.red = 8'($urandom);
      r.green = 8'($urandom);
      r.blue = 8'($urandom);
      n = leds_in_use();
      roll = $urandom_range(0, 99);
      if (busy_q) begin
         r.cmd = (roll < 80) ? CMD_TICK : (roll < 92) ? CMD_SET_PIXEL :
                 (roll < 96) ? CMD_START : CMD_SET_ALL;
      end else begin
         r.cmd = (roll < 40) ? CMD_SET_PIXEL : (roll < 70) ? CMD_START :
                 (roll < 85) ? CMD_SET_ALL : CMD_TICK;
      end
      if (r.cmd == CMD_SET_PIXEL && n > 0 && $urandom_range(0, 4) != 0)
         r.pixel_index = 5'($urandom_range(0, n - 1));
      return r;
   endfunction

   function automatic cfg_type phase_setup(int p);
      cfg_type c;
      case (p)
         1: c = '{6'd2, 8'd1, 8'd0, 8'd255, 10'd0};
         2: c = '{6'd0, 8'd3, 8'd1, 8'd2, 10'd0};
         3: c = '{6'd0, 8'd0, 8'd0, 8'd1, 10'd5};
         4: c = '{6'd63, 8'd0, 8'd0, 8'd1, 10'd1};
         5: c = '{6'd1, 8'd255, 8'd255, 8'd0, 10'd1023};
         6: c = '{6'd3, 8'd2, 8'd1, 8'd2, 10'd2};
         7: c = '{6'd4, 8'd0, 8'd0, 8'd1, 10'd3};
         default: begin
            c.led_count = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63))
                                                      : 6'($urandom_range(0, 5));
            c.bit_period = 8'($urandom_range(0, 3));
            c.zero_high_ticks = 8'($urandom_range(0, 4));
            c.one_high_ticks = 8'($urandom_range(0, 4));
            c.reset_bit_count = 10'($urandom_range(0, 4));
         end
      endcase
      return c;
   endfunction

   task automatic put_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
   endtask

   task automatic wait_quiet();
      do @(negedge clock); while (pixel_cmds.size() != 0 || req_valid || strip_rsp_due.size() != 0);
   endtask

   // Command driver: holds each transfer until it is taken, then idles at random.
   always @(negedge clock) begin
      if (!req_valid || req_took) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pixel_cmds.size() != 0) begin
            req_payload <= pixel_cmds.pop_front();
            req_valid <= 1'b1;
            send_gap = idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, plus one long hold-off on request.
   always @(negedge clock) begin
      if (hold_done != hold_asked) begin
         hold_done = hold_asked;
         rsp_wait = LONG_HOLD;
      end
      if (rsp_wait > 0) begin
         rsp_ready <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_ready <= 1'b1;
         rsp_wait = idle_len();
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_took = 1'b0;
      end else begin
         req_took = req_valid && req_ready;
         if (req_took) begin
            want = strip_next(req_payload);
            strip_rsp_due.push_back(want);
            items_sent++;
            if (want.accepted) taken_items++;
         end
         if (csr_valid && csr_ready) begin
            reg_store(csr_index, csr_wdata);
            reg_writes++;
         end
         if (rsp_valid && rsp_ready) begin
            if (strip_rsp_due.size() == 0) begin
               $error("result transfer with no command outstanding");
               err_count++;
            end else begin
               want = strip_rsp_due.pop_front();
               if (rsp_payload.data_level !== want.data_level) begin
                  $error("data_level: expected %0b, got %0b", want.data_level,
                         rsp_payload.data_level);
                  err_count++;
               end
               if (rsp_payload.busy_res !== want.busy_res) begin
                  $error("busy_res: expected %0b, got %0b", want.busy_res, rsp_payload.busy_res);
                  err_count++;
               end
               if (rsp_payload.accepted !== want.accepted) begin
                  $error("accepted: expected %0b, got %0b", want.accepted, rsp_payload.accepted);
                  err_count++;
               end
            end
         end
      end
   end

   initial begin
      cfg_type setup;
      int      goal;
      bit      paused;
      for (int i = 0; i < MAX_LEDS; i++) pixel_mem[i] = '0;
      frame_clear();
      paused = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: 25 LEDs, so indexes 25 and 31 fall outside the chain.
      pixel_cmds.push_back(led_cmd(CMD_TICK, 0, 0, 0, 0));
      pixel_cmds.push_back(led_cmd(CMD_SET_PIXEL, 0, 8'hFF, 8'h00, 8'hFF));
      pixel_cmds.push_back(led_cmd(CMD_SET_PIXEL, 31, 8'hFF, 8'hFF, 8'hFF));
      pixel_cmds.push_back(led_cmd(CMD_SET_PIXEL, 25, 8'h01, 8'h02, 8'h03));
      pixel_cmds.push_back(led_cmd(CMD_SET_PIXEL, 24, 8'hFF, 8'hFF, 8'hFF));
      pixel_cmds.push_back(led_cmd(CMD_SET_PIXEL, 1, 8'hAA, 8'h55, 8'h01));
      pixel_cmds.push_back(led_cmd(CMD_START, 0, 0, 0, 0));
      pixel_cmds.push_back(led_cmd(CMD_START, 0, 0, 0, 0));
      pixel_cmds.push_back(led_cmd(CMD_SET_ALL, 0, 8'h12, 8'h34, 8'h56));
      pixel_cmds.push_back(led_cmd(CMD_SET_PIXEL, 0, 8'h00, 8'h00, 8'h00));
      pixel_cmds.push_back(led_cmd(CMD_SET_PIXEL, 2, 8'h00, 8'h80, 8'h7F));
      repeat (5) pixel_cmds.push_back(led_cmd(CMD_TICK, 31, 8'hFF, 8'hFF, 8'hFF));

      for (int p = 0; p < PHASES; p++) begin
         wait_quiet();
         if (p > 0) begin
            // Registers change between phases, often while a frame is still running.
            setup = phase_setup(p);
            put_reg(CSR_LED_COUNT, CSR_DATA_W'(setup.led_count));
            put_reg(CSR_BIT_PERIOD, CSR_DATA_W'(setup.bit_period));
            put_reg(CSR_ZERO_HIGH, CSR_DATA_W'(setup.zero_high_ticks));
            put_reg(CSR_ONE_HIGH, CSR_DATA_W'(setup.one_high_ticks));
            put_reg(CSR_RESET_BITS, setup.reset_bit_count);
            @(negedge clock);
            csr_valid <= 1'b0;
         end
         no_idle = (p % 4 == 3);
         if (p == 5) hold_asked++;
         pixel_cmds.push_back(led_cmd(CMD_START, 0, 0, 0, 0));
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) begin
            if (p == 7 && !paused && items_sent >= goal - PHASE_ITEMS / 2) begin
               wait_quiet();
               paused = 1'b1;
            end
            @(negedge clock);
            if (pixel_cmds.size() < 4) pixel_cmds.push_back(random_cmd());
         end
      end

      wait_quiet();
      repeat (50) @(posedge clock);
      $display("Sent %0d commands (%0d took effect), %0d register writes, %0d frames ended.",
               items_sent, taken_items, reg_writes, frames_done);
      if (err_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
